// ===== rtl/core/epsc_pkg.sv =====
`default_nettype none

package epsc_pkg;

    localparam int unsigned TIME_W  = 31;
    localparam int unsigned YEAR_W  = 11;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned WD_W    = 3;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned STEP_W  = 3;

    localparam logic [TIME_W-1:0]  SECS_COMMON_YEAR = 31'd31536000;
    localparam logic [TIME_W-1:0]  SECS_LEAP_YEAR   = 31'd31622400;
    localparam logic [TIME_W-1:0]  SECS_DAY         = 31'd86400;
    localparam logic [TIME_W-1:0]  SECS_HOUR        = 31'd3600;
    localparam logic [TIME_W-1:0]  SECS_MINUTE      = 31'd60;
    localparam logic [YEAR_W-1:0]  FIRST_YEAR       = 11'd1970;
    localparam logic [MONTH_W-1:0] FIRST_MONTH      = 4'd1;
    localparam logic [MONTH_W-1:0] LAST_MONTH       = 4'd12;
    localparam logic [WD_W-1:0]    FIRST_WEEKDAY    = 3'd4;
    localparam logic [WD_W-1:0]    DAYS_PER_WEEK    = 3'd7;

    // Top bit index of each restoring-division phase
    localparam logic [STEP_W-1:0]  DAY_TOP_STEP  = 3'd4;
    localparam logic [STEP_W-1:0]  HOUR_TOP_STEP = 3'd4;
    localparam logic [STEP_W-1:0]  MIN_TOP_STEP  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_DONE
    } state_t;

    function automatic logic [DAY_W-1:0] month_days(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] d;
        begin
            case (month)
                4'd2:                      d = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
                default:                   d = 5'd31;
            endcase
            return d;
        end
    endfunction

    function automatic logic [TIME_W-1:0] month_span(input logic [DAY_W-1:0] md);
        logic [TIME_W-1:0] s;
        begin
            case (md)
                5'd28:   s = 31'd2419200;
                5'd29:   s = 31'd2505600;
                5'd30:   s = 31'd2592000;
                default: s = 31'd2678400;
            endcase
            return s;
        end
    endfunction

    // (wd + inc) mod 7, wd in 0..6, inc in 0..6
    function automatic logic [WD_W-1:0] wd_add(
        input logic [WD_W-1:0] wd,
        input logic [WD_W-1:0] inc
    );
        logic [WD_W:0] s;
        begin
            s = {1'b0, wd} + {1'b0, inc};
            if (s >= {1'b0, DAYS_PER_WEEK}) begin
                s = s - {1'b0, DAYS_PER_WEEK};
            end
            return s[WD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/epoch_seconds_to_calendar_top.sv =====
// Sequence: after an input transfer the year loop, the month loop and the bit-serial day,
// hour and minute divisions run in turn before the result reaches the output register.
// No new item is taken until the conversion finishes; one compare/subtract unit
// is reused for the year and month loops and for the bit-serial day, hour and minute
// divisions. A finished result waits in an output register, so the next item can be taken
// while it is pending.
// Reset: asynchronous active low, clears the sequencer and output valid; no other state.
`default_nettype none

module epoch_seconds_to_calendar_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [epsc_pkg::TIME_W-1:0]   epoch_seconds,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [epsc_pkg::YEAR_W-1:0]   year_out,
    output logic      [epsc_pkg::MONTH_W-1:0]  month_out,
    output logic      [epsc_pkg::DAY_W-1:0]    day_of_month,
    output logic      [epsc_pkg::WD_W-1:0]     weekday,
    output logic      [epsc_pkg::HOUR_W-1:0]   hour_out,
    output logic      [epsc_pkg::MIN_W-1:0]    minute_out,
    output logic      [epsc_pkg::SEC_W-1:0]    second_out
);
    import epsc_pkg::*;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [TIME_W-1:0]   t_reg, t_next;
    logic [YEAR_W-1:0]   year_reg, year_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [DAY_W-1:0]    days_reg, days_next;
    logic [WD_W-1:0]     wd_reg, wd_next;
    logic [HOUR_W-1:0]   hour_reg, hour_next;
    logic [MIN_W-1:0]    min_reg, min_next;

    logic                out_valid_reg, out_valid_next;
    logic [YEAR_W-1:0]   year_out_reg;
    logic [MONTH_W-1:0]  month_out_reg;
    logic [DAY_W-1:0]    dom_out_reg;
    logic [WD_W-1:0]     wd_out_reg;
    logic [HOUR_W-1:0]   hour_out_reg;
    logic [MIN_W-1:0]    min_out_reg;
    logic [SEC_W-1:0]    sec_out_reg;

    logic                leap;
    logic [DAY_W-1:0]    md;
    logic [TIME_W-1:0]   divisor;
    logic [TIME_W:0]     diff;
    logic                ge;
    logic                in_xfer;
    logic                out_load;
    logic [WD_W-1:0]     bit_wd_inc;

    assign in_xfer  = in_valid && in_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Years stay within 1970..2038, so divisible-by-4 is the whole rule (2000 is a leap year)
    assign leap = (year_reg[1:0] == 2'b00);
    assign md   = month_days(month_reg, leap);

    // Shared compare/subtract unit
    always_comb
    begin
        unique case (state_reg)
            ST_YEAR:  divisor = leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
            ST_MONTH: divisor = month_span(md);
            ST_DAY:   divisor = SECS_DAY << step_reg;
            ST_HOUR:  divisor = SECS_HOUR << step_reg;
            ST_MIN:   divisor = SECS_MINUTE << step_reg;
            default:  divisor = SECS_DAY;
        endcase
    end

    assign diff = {1'b0, t_reg} - {1'b0, divisor};
    assign ge   = !diff[TIME_W];

    // 2^step mod 7
    always_comb
    begin
        case (step_reg) inside
            3'd0, 3'd3: bit_wd_inc = 3'd1;
            3'd1, 3'd4: bit_wd_inc = 3'd2;
            3'd2:       bit_wd_inc = 3'd4;
            default:    bit_wd_inc = 3'd0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_xfer) state_next = ST_YEAR;
            ST_YEAR:  if (!ge) state_next = ST_MONTH;
            ST_MONTH: if (month_reg == LAST_MONTH || !ge) state_next = ST_DAY;
            ST_DAY:   if (step_reg == '0) state_next = ST_HOUR;
            ST_HOUR:  if (step_reg == '0) state_next = ST_MIN;
            ST_MIN:   if (step_reg == '0) state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath
    always_comb
    begin
        step_next  = step_reg;
        t_next     = t_reg;
        year_next  = year_reg;
        month_next = month_reg;
        days_next  = days_reg;
        wd_next    = wd_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_xfer) begin
                    t_next     = epoch_seconds;
                    year_next  = FIRST_YEAR;
                    month_next = FIRST_MONTH;
                    days_next  = '0;
                    wd_next    = FIRST_WEEKDAY;
                    hour_next  = '0;
                    min_next   = '0;
                end
            end
            ST_YEAR:
            begin
                if (ge) begin
                    t_next    = diff[TIME_W-1:0];
                    year_next = year_reg + YEAR_W'(1);
                    wd_next   = wd_add(wd_reg, leap ? 3'd2 : 3'd1);
                end
            end
            ST_MONTH:
            begin
                if (month_reg != LAST_MONTH && ge) begin
                    t_next     = diff[TIME_W-1:0];
                    month_next = month_reg + MONTH_W'(1);
                    wd_next    = wd_add(wd_reg, WD_W'(md - DAY_W'(28)));
                end else begin
                    step_next = DAY_TOP_STEP;
                end
            end
            ST_DAY:
            begin
                if (ge) begin
                    t_next    = diff[TIME_W-1:0];
                    days_next = days_reg | (DAY_W'(1) << step_reg);
                    wd_next   = wd_add(wd_reg, bit_wd_inc);
                end
                step_next = (step_reg == '0) ? HOUR_TOP_STEP : step_reg - STEP_W'(1);
            end
            ST_HOUR:
            begin
                if (ge) begin
                    t_next    = diff[TIME_W-1:0];
                    hour_next = hour_reg | (HOUR_W'(1) << step_reg);
                end
                step_next = (step_reg == '0) ? MIN_TOP_STEP : step_reg - STEP_W'(1);
            end
            ST_MIN:
            begin
                if (ge) begin
                    t_next   = diff[TIME_W-1:0];
                    min_next = min_reg | (MIN_W'(1) << step_reg);
                end
                if (step_reg != '0) begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        t_reg     <= t_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        days_reg  <= days_next;
        wd_reg    <= wd_next;
        hour_reg  <= hour_next;
        min_reg   <= min_next;
        if (out_load) begin
            year_out_reg  <= year_reg;
            month_out_reg <= month_reg;
            dom_out_reg   <= days_reg + DAY_W'(1);
            wd_out_reg    <= wd_reg;
            hour_out_reg  <= hour_reg;
            min_out_reg   <= min_reg;
            sec_out_reg   <= t_reg[SEC_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign year_out     = year_out_reg;
    assign month_out    = month_out_reg;
    assign day_of_month = dom_out_reg;
    assign weekday      = wd_out_reg;
    assign hour_out     = hour_out_reg;
    assign minute_out   = min_out_reg;
    assign second_out   = sec_out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/epsc_checker.sv =====
`default_nettype none

module epsc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic [epsc_pkg::TIME_W-1:0]   epoch_seconds,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [epsc_pkg::YEAR_W-1:0]   year_out,
    input wire logic [epsc_pkg::MONTH_W-1:0]  month_out,
    input wire logic [epsc_pkg::DAY_W-1:0]    day_of_month,
    input wire logic [epsc_pkg::WD_W-1:0]     weekday,
    input wire logic [epsc_pkg::HOUR_W-1:0]   hour_out,
    input wire logic [epsc_pkg::MIN_W-1:0]    minute_out,
    input wire logic [epsc_pkg::SEC_W-1:0]    second_out
);
    import epsc_pkg::*;

    // After a transfer the input is no longer ready
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a conversion runs");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(year_out) && $stable(month_out)
            && $stable(day_of_month) && $stable(weekday) && $stable(hour_out)
            && $stable(minute_out) && $stable(second_out)))
        else $error("stalled result changed");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (year_out >= FIRST_YEAR && year_out <= 11'd2038
            && month_out >= FIRST_MONTH && month_out <= LAST_MONTH
            && day_of_month >= 5'd1 && weekday < DAYS_PER_WEEK))
        else $error("date field out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hour_out <= 5'd23 && minute_out <= 6'd59 && second_out <= 6'd59))
        else $error("time field out of range");

endmodule

bind epoch_seconds_to_calendar_top epsc_checker u_epsc_checker (.*);

`default_nettype wire
